FILE: rtl/core/overlap_add_fft_filter_assert.svh
// Assertion macros shared by the overlap-add filter.
`ifndef OVERLAP_ADD_FFT_FILTER_ASSERT_SVH
`define OVERLAP_ADD_FFT_FILTER_ASSERT_SVH

// Checks the consequence in the same cycle as the antecedent.
`define OLAFFT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks the consequence in the cycle after the antecedent.
`define OLAFFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/olafft_pkg.sv
// Shared constants, types and tables of the overlap-add filter.
`default_nettype none
package olafft_pkg;

  localparam int FFT_SIZE_DEF    = 32;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int IDX_W           = 5;
  localparam int HOP_W           = 6;
  localparam logic [HOP_W-1:0] HOP_RESET = 6'd16;
  localparam int COEF_W          = 16;
  localparam int GAIN_DEPTH      = 17;
  localparam int ACC_W           = 24;
  localparam int H_W             = 18;
  localparam int COS_W           = 17;
  localparam int OPC_W           = 2;

  localparam logic [OPC_W-1:0] OPC_WIN    = 2'd0;
  localparam logic [OPC_W-1:0] OPC_GAIN   = 2'd1;
  localparam logic [OPC_W-1:0] OPC_SAMPLE = 2'd2;

  typedef logic [1:0] dp_op_t;
  localparam dp_op_t DP_KERN = 2'd0;
  localparam dp_op_t DP_WIN  = 2'd1;
  localparam dp_op_t DP_CONV = 2'd2;
  localparam dp_op_t DP_EMIT = 2'd3;

  typedef struct packed {
    logic             valid;
    dp_op_t           op;
    logic             first;
    logic             last;
    logic             zero;
    logic             eos;
    logic             take;
    logic [IDX_W-1:0] outer;
    logic [IDX_W-1:0] inner;
    logic [IDX_W-1:0] hist_addr;
    logic [IDX_W-1:0] acc_addr;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic emit_ok;
  } dp_stat_t;

  function automatic logic signed [COS_W-1:0] cos_q15(input logic [IDX_W-1:0] t);
    logic signed [COS_W-1:0] c;
    case (t)
      5'd0:  c = 17'sd32768;
      5'd1:  c = 17'sd32139;
      5'd2:  c = 17'sd30273;
      5'd3:  c = 17'sd27246;
      5'd4:  c = 17'sd23170;
      5'd5:  c = 17'sd18205;
      5'd6:  c = 17'sd12540;
      5'd7:  c = 17'sd6393;
      5'd8:  c = 17'sd0;
      5'd9:  c = -17'sd6393;
      5'd10: c = -17'sd12540;
      5'd11: c = -17'sd18205;
      5'd12: c = -17'sd23170;
      5'd13: c = -17'sd27246;
      5'd14: c = -17'sd30273;
      5'd15: c = -17'sd32139;
      5'd16: c = -17'sd32768;
      5'd17: c = -17'sd32139;
      5'd18: c = -17'sd30273;
      5'd19: c = -17'sd27246;
      5'd20: c = -17'sd23170;
      5'd21: c = -17'sd18205;
      5'd22: c = -17'sd12540;
      5'd23: c = -17'sd6393;
      5'd24: c = 17'sd0;
      5'd25: c = 17'sd6393;
      5'd26: c = 17'sd12540;
      5'd27: c = 17'sd18205;
      5'd28: c = 17'sd23170;
      5'd29: c = 17'sd27246;
      5'd30: c = 17'sd30273;
      default: c = 17'sd32139;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/olafft_in_if.sv
// Input channel of the overlap-add filter: loads and audio samples.
`default_nettype none
interface olafft_in_if #(
  parameter int SAMPLE_BITS = olafft_pkg::SAMPLE_BITS_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic [olafft_pkg::OPC_W-1:0]         opcode;
  logic [olafft_pkg::IDX_W-1:0]         table_index;
  logic [olafft_pkg::COEF_W-1:0]        table_value;
  logic signed [SAMPLE_BITS-1:0]        sample_in;
  logic                                 is_last;

  modport source (output valid, opcode, table_index, table_value, sample_in, is_last,
                  input ready);
  modport sink (input valid, opcode, table_index, table_value, sample_in, is_last,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/core/olafft_out_if.sv
// Output channel of the overlap-add filter: filtered samples.
`default_nettype none
interface olafft_out_if #(
  parameter int SAMPLE_BITS = olafft_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;
  logic                          end_of_signal;

  modport source (output valid, sample_out, clipped, end_of_signal, input ready);
  modport sink (input valid, sample_out, clipped, end_of_signal, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/olafft_ctrl.sv
// Frame sequencer of the overlap-add filter: counters, pointers and phase control.
`default_nettype none
module olafft_ctrl #(
  parameter int FFT_SIZE = olafft_pkg::FFT_SIZE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [olafft_pkg::HOP_W-1:0]  cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [olafft_pkg::OPC_W-1:0]  in_opcode,
  input  wire logic                          in_is_last,
  output olafft_pkg::dp_cmd_t                cmd,
  input  wire olafft_pkg::dp_stat_t          stat
);
  localparam int LG    = $clog2(FFT_SIZE);
  localparam int CNT_W = LG + 1;
  localparam int IW    = olafft_pkg::IDX_W;
  localparam logic [LG-1:0]    LAST_IDX = LG'(FFT_SIZE - 1);
  localparam logic [CNT_W-1:0] FULL     = CNT_W'(FFT_SIZE);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_KERN = 3'd1;
  localparam logic [2:0] S_WIN  = 3'd2;
  localparam logic [2:0] S_CONV = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]                   state;
  logic [2:0]                   resume;
  logic [LG-1:0]                i;
  logic [LG-1:0]                j;
  logic [CNT_W-1:0]             cnt;
  logic [LG-1:0]                hbase;
  logic [LG-1:0]                abase;
  logic                         flush;
  logic                         final_frm;
  logic [CNT_W-1:0]             ecnt;
  logic [olafft_pkg::HOP_W-1:0] hop_size;
  logic [CNT_W-1:0]             hop_use;
  logic                         last_word;
  logic                         tail;

  always_comb begin
    if (hop_size == '0) begin
      hop_use = CNT_W'(1);
    end else if (hop_size > olafft_pkg::HOP_W'(FFT_SIZE)) begin
      hop_use = FULL;
    end else begin
      hop_use = hop_size[CNT_W-1:0];
    end
  end

  assign tail      = flush && (cnt <= hop_use);
  assign last_word = ({1'b0, j} == (ecnt - CNT_W'(1)));
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.take      = in_valid;
        cmd.hist_addr = IW'(hbase + cnt[LG-1:0]);
      end
      S_KERN, S_CONV: begin
        cmd.valid    = 1'b1;
        cmd.op       = (state == S_KERN) ? olafft_pkg::DP_KERN : olafft_pkg::DP_CONV;
        cmd.first    = (j == '0);
        cmd.last     = (j == LAST_IDX);
        cmd.outer    = IW'(i);
        cmd.inner    = IW'(j);
        cmd.acc_addr = IW'(abase + i);
      end
      S_WIN: begin
        cmd.valid     = 1'b1;
        cmd.op        = olafft_pkg::DP_WIN;
        cmd.first     = 1'b1;
        cmd.last      = 1'b1;
        cmd.zero      = ({1'b0, j} >= cnt);
        cmd.outer     = IW'(j);
        cmd.inner     = IW'(j);
        cmd.hist_addr = IW'(hbase + j);
      end
      S_EMIT: begin
        cmd.valid    = stat.emit_ok;
        cmd.op       = olafft_pkg::DP_EMIT;
        cmd.eos      = final_frm && last_word;
        cmd.acc_addr = IW'(abase + j);
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      resume    <= S_IDLE;
      i         <= '0;
      j         <= '0;
      cnt       <= '0;
      hbase     <= '0;
      abase     <= '0;
      flush     <= 1'b0;
      final_frm <= 1'b0;
      ecnt      <= '0;
      hop_size  <= olafft_pkg::HOP_RESET;
    end else begin
      if (cfg_we) begin
        hop_size <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_opcode == olafft_pkg::OPC_SAMPLE) begin
            cnt <= cnt + CNT_W'(1);
            i   <= '0;
            j   <= '0;
            if (in_is_last) begin
              flush <= 1'b1;
              state <= S_KERN;
            end else if ((cnt + CNT_W'(1)) == FULL) begin
              state <= S_KERN;
            end
          end
        end
        S_KERN, S_CONV: begin
          j <= j + LG'(1);
          if (j == LAST_IDX) begin
            i <= i + LG'(1);
            if (i == LAST_IDX) begin
              resume <= (state == S_KERN) ? S_WIN : S_EMIT;
              state  <= S_WAIT;
            end
          end
        end
        S_WIN: begin
          j <= j + LG'(1);
          if (j == LAST_IDX) begin
            resume <= S_CONV;
            state  <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (!stat.busy) begin
            state <= resume;
            if (resume == S_EMIT) begin
              final_frm <= tail;
              ecnt      <= tail ? FULL : hop_use;
            end
          end
        end
        S_EMIT: begin
          if (stat.emit_ok) begin
            j <= j + LG'(1);
            if (last_word) begin
              j     <= '0;
              i     <= '0;
              abase <= abase + ecnt[LG-1:0];
              if (final_frm) begin
                hbase <= '0;
                cnt   <= '0;
                flush <= 1'b0;
                state <= S_IDLE;
              end else begin
                hbase <= hbase + hop_use[LG-1:0];
                cnt   <= cnt - hop_use;
                state <= flush ? S_KERN : S_IDLE;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/olafft_dp.sv
// Datapath of the overlap-add filter: tables, shared multiply-accumulate and output register.
`default_nettype none
module olafft_dp #(
  parameter int FFT_SIZE    = olafft_pkg::FFT_SIZE_DEF,
  parameter int SAMPLE_BITS = olafft_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire olafft_pkg::dp_cmd_t            cmd,
  output olafft_pkg::dp_stat_t                stat,
  input  wire logic [olafft_pkg::OPC_W-1:0]   in_opcode,
  input  wire logic [olafft_pkg::IDX_W-1:0]   in_table_index,
  input  wire logic [olafft_pkg::COEF_W-1:0]  in_table_value,
  input  wire logic signed [SAMPLE_BITS-1:0]  in_sample,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_sample,
  output logic                                out_clipped,
  output logic                                out_eos
);
  localparam int LG    = $clog2(FFT_SIZE);
  localparam int IW    = olafft_pkg::IDX_W;
  localparam int CW    = olafft_pkg::COEF_W;
  localparam int AW    = olafft_pkg::ACC_W;
  localparam int HW    = olafft_pkg::H_W;
  localparam int V_W   = SAMPLE_BITS + 2;
  localparam int A_W   = (V_W > olafft_pkg::COS_W) ? V_W : olafft_pkg::COS_W;
  localparam int P_W   = A_W + HW;
  localparam int S_W   = P_W + LG + 1;
  localparam int KSH   = 15 + LG;
  localparam logic [LG:0] HALF = (LG + 1)'(FFT_SIZE / 2);
  localparam logic signed [S_W-1:0] K_HALF = S_W'(1) << (KSH - 1);
  localparam logic signed [S_W-1:0] W_HALF = S_W'(1) << 14;
  localparam logic signed [S_W-1:0] C_HALF = S_W'(1) << 11;
  localparam logic signed [S_W-1:0] ACC_MAXV = S_W'(2 ** (AW - 1) - 1);
  localparam logic signed [S_W-1:0] ACC_MINV = ~ACC_MAXV;
  localparam logic signed [AW-1:0]  OUT_MAX  = AW'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam logic signed [AW-1:0]  OUT_MIN  = ~OUT_MAX;

  logic [CW-1:0]                win_mem  [FFT_SIZE];
  logic [CW-1:0]                gain_mem [olafft_pkg::GAIN_DEPTH];
  logic signed [SAMPLE_BITS-1:0] hist_mem [FFT_SIZE];
  logic signed [V_W-1:0]        v_mem    [FFT_SIZE];
  logic signed [HW-1:0]         h_mem    [FFT_SIZE];
  logic signed [AW-1:0]         acc_mem  [FFT_SIZE];
  logic [FFT_SIZE-1:0]          acc_vld;

  logic [LG-1:0]   ii;
  logic [LG-1:0]   oo;
  logic [LG:0]     mirror;
  logic [IW-1:0]   gain_addr;
  logic [2*LG-1:0] prod_ij;
  logic [IW-1:0]   cos_addr;
  logic [LG-1:0]   h_addr;

  logic [CW-1:0]                gain_rd;
  logic signed [olafft_pkg::COS_W-1:0] cos_rd;
  logic [CW-1:0]                win_rd;
  logic signed [SAMPLE_BITS-1:0] hist_rd;
  logic signed [V_W-1:0]        v_rd;
  logic signed [HW-1:0]         h_rd;
  logic signed [AW-1:0]         acc_rd;
  logic                         accv_rd;

  logic               v1;
  olafft_pkg::dp_op_t op1;
  logic               first1, last1, zero1, eos1;
  logic [LG-1:0]      o1, addr1;
  logic signed [A_W-1:0] a_op;
  logic signed [HW-1:0]  b_op;
  logic signed [P_W-1:0] p_mul;
  logic signed [AW-1:0]  acc_old1;
  logic                  emit1;

  logic               v2;
  olafft_pkg::dp_op_t op2;
  logic               first2, last2;
  logic [LG-1:0]      o2, addr2;
  logic signed [P_W-1:0] p2;
  logic signed [AW-1:0]  accold2;

  logic               fin3;
  olafft_pkg::dp_op_t op3;
  logic [LG-1:0]      o3, addr3;
  logic signed [S_W-1:0] sum3;
  logic signed [AW-1:0]  accold3;

  logic signed [S_W-1:0] k_round, w_round, c_round, a_sum;
  logic signed [AW-1:0]  acc_new;

  assign ii        = cmd.inner[LG-1:0];
  assign oo        = cmd.outer[LG-1:0];
  assign mirror    = (LG + 1)'(FFT_SIZE) - {1'b0, ii};
  assign gain_addr = ({1'b0, ii} <= HALF) ? IW'(ii) : IW'(mirror);
  assign prod_ij   = (2 * LG)'(oo) * (2 * LG)'(ii);
  assign cos_addr  = IW'(prod_ij[LG-1:0]) << (IW - LG);
  assign h_addr    = oo - ii;

  always_ff @(posedge clk) begin
    gain_rd <= gain_mem[gain_addr];
    cos_rd  <= olafft_pkg::cos_q15(cos_addr);
    win_rd  <= win_mem[ii];
    hist_rd <= hist_mem[cmd.hist_addr[LG-1:0]];
    v_rd    <= v_mem[ii];
    h_rd    <= h_mem[h_addr];
    acc_rd  <= acc_mem[cmd.acc_addr[LG-1:0]];
    accv_rd <= acc_vld[cmd.acc_addr[LG-1:0]];
    if (cmd.take && in_opcode == olafft_pkg::OPC_WIN &&
        {1'b0, in_table_index} < (IW + 1)'(FFT_SIZE)) begin
      win_mem[in_table_index[LG-1:0]] <= in_table_value;
    end
    if (cmd.take && in_opcode == olafft_pkg::OPC_GAIN &&
        {1'b0, in_table_index} < (IW + 1)'(olafft_pkg::GAIN_DEPTH)) begin
      gain_mem[in_table_index] <= in_table_value;
    end
    if (cmd.take && in_opcode == olafft_pkg::OPC_SAMPLE) begin
      hist_mem[cmd.hist_addr[LG-1:0]] <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    op1    <= cmd.op;
    first1 <= cmd.first;
    last1  <= cmd.last;
    zero1  <= cmd.zero;
    eos1   <= cmd.eos;
    o1     <= oo;
    addr1  <= cmd.acc_addr[LG-1:0];
  end

  always_comb begin
    case (op1)
      olafft_pkg::DP_KERN: begin
        a_op = A_W'(cos_rd);
        b_op = $signed({2'b00, gain_rd});
      end
      olafft_pkg::DP_WIN: begin
        a_op = zero1 ? '0 : A_W'(hist_rd);
        b_op = $signed({2'b00, win_rd});
      end
      olafft_pkg::DP_CONV: begin
        a_op = A_W'(v_rd);
        b_op = h_rd;
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign p_mul    = a_op * b_op;
  assign acc_old1 = accv_rd ? acc_rd : '0;
  assign emit1    = v1 && (op1 == olafft_pkg::DP_EMIT);

  always_ff @(posedge clk) begin
    p2      <= p_mul;
    op2     <= op1;
    first2  <= first1;
    last2   <= last1;
    o2      <= o1;
    addr2   <= addr1;
    accold2 <= acc_old1;
    if (v2) begin
      sum3    <= first2 ? S_W'(p2) : sum3 + S_W'(p2);
      op3     <= op2;
      o3      <= o2;
      addr3   <= addr2;
      accold3 <= accold2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      fin3 <= 1'b0;
    end else begin
      v1   <= cmd.valid;
      v2   <= v1 && !emit1;
      fin3 <= v2 && last2;
    end
  end

  assign k_round = (sum3 + K_HALF) >>> KSH;
  assign w_round = (sum3 + W_HALF) >>> 15;
  assign c_round = (sum3 + C_HALF) >>> 12;
  assign a_sum   = c_round + S_W'(accold3);

  always_comb begin
    if (a_sum > ACC_MAXV) begin
      acc_new = ACC_MAXV[AW-1:0];
    end else if (a_sum < ACC_MINV) begin
      acc_new = ACC_MINV[AW-1:0];
    end else begin
      acc_new = a_sum[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (fin3 && op3 == olafft_pkg::DP_KERN) begin
      h_mem[o3] <= k_round[HW-1:0];
    end
    if (fin3 && op3 == olafft_pkg::DP_WIN) begin
      v_mem[o3] <= w_round[V_W-1:0];
    end
    if (fin3 && op3 == olafft_pkg::DP_CONV) begin
      acc_mem[addr3] <= acc_new;
    end else if (emit1) begin
      acc_mem[addr1] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_vld <= '0;
    end else if (fin3 && op3 == olafft_pkg::DP_CONV) begin
      acc_vld[addr3] <= 1'b1;
    end else if (emit1) begin
      acc_vld[addr1] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit1) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit1) begin
      out_eos <= eos1;
      if (acc_old1 > OUT_MAX) begin
        out_sample  <= OUT_MAX[SAMPLE_BITS-1:0];
        out_clipped <= 1'b1;
      end else if (acc_old1 < OUT_MIN) begin
        out_sample  <= OUT_MIN[SAMPLE_BITS-1:0];
        out_clipped <= 1'b1;
      end else begin
        out_sample  <= acc_old1[SAMPLE_BITS-1:0];
        out_clipped <= 1'b0;
      end
    end
  end

  assign stat.busy    = v1 || v2 || fin3;
  assign stat.emit_ok = !emit1 && (!out_valid || out_ready);
endmodule
`default_nettype wire

FILE: rtl/core/overlap_add_fft_filter.sv
// Top level of the overlap-add FFT filter: sequencer, datapath and assertions.
// Usage: din carries one word per handshake. Opcode 0 loads a window coefficient,
// opcode 1 loads a bin gain, opcode 2 delivers an audio sample; is_last on a sample
// starts the flush of the signal. cfg_we and cfg_wdata write hop_size; the user is
// to write it only while idle, and the block itself does not enforce this. dout
// carries filtered samples with a clipped flag and end_of_signal on the final word
// of a flushed signal. Loads and samples that do not complete a frame leave din
// ready. A completed frame runs one shared multiply-accumulate unit through the
// filter kernel (N*N steps), the window (N steps) and the circular convolution
// (N*N steps), then emits as many words as the hop (hop_size held to 1..N), or N
// words on the final frame of a flush, one at a time as the output register has
// room; the sustained cost per sample is the frame time divided by the hop. A flush
// runs up to N frames back to back. din is not ready while a frame or a flush is in
// progress. The last word sits in an output register, so a new word is taken while
// it waits; a stalled receiver holds up only further words.
// Reset clears history, accumulator, pointers and sets hop_size to 16; the window
// and gain tables keep no reset value and must be loaded before use.
`default_nettype none
`include "overlap_add_fft_filter_assert.svh"
module overlap_add_fft_filter #(
  parameter int FFT_SIZE    = olafft_pkg::FFT_SIZE_DEF,
  parameter int SAMPLE_BITS = olafft_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [olafft_pkg::HOP_W-1:0] cfg_wdata,
  olafft_in_if.sink                         din,
  olafft_out_if.source                      dout
);
  olafft_pkg::dp_cmd_t  dp_cmd;
  olafft_pkg::dp_stat_t dp_stat;
  logic                          in_ready;
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          out_clipped;
  logic                          out_eos;

  olafft_ctrl #(
    .FFT_SIZE(FFT_SIZE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (din.valid),
    .in_ready  (in_ready),
    .in_opcode (din.opcode),
    .in_is_last(din.is_last),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

  olafft_dp #(
    .FFT_SIZE   (FFT_SIZE),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (dp_cmd),
    .stat          (dp_stat),
    .in_opcode     (din.opcode),
    .in_table_index(din.table_index),
    .in_table_value(din.table_value),
    .in_sample     (din.sample_in),
    .out_valid     (out_valid),
    .out_ready     (dout.ready),
    .out_sample    (out_sample),
    .out_clipped   (out_clipped),
    .out_eos       (out_eos)
  );

  assign din.ready          = in_ready;
  assign dout.valid         = out_valid;
  assign dout.sample_out    = out_sample;
  assign dout.clipped       = out_clipped;
  assign dout.end_of_signal = out_eos;

  `OLAFFT_ASSERT_NEXT(a_last_starts_flush,
    din.valid && din.ready && din.opcode == olafft_pkg::OPC_SAMPLE && din.is_last,
    !din.ready, "last sample did not start a flush")
  `OLAFFT_ASSERT_SAME(a_frame_work_blocks_input,
    dp_cmd.valid && dp_cmd.op != olafft_pkg::DP_EMIT,
    !din.ready, "frame work issued while input is open")
  `OLAFFT_ASSERT_SAME(a_emit_has_room,
    dp_cmd.valid && dp_cmd.op == olafft_pkg::DP_EMIT,
    !dout.valid || dout.ready, "word issued with no room in the output register")
endmodule
`default_nettype wire

FILE: sim/tb_overlap_add_fft_filter.sv
// Self-checking testbench of the overlap-add FFT filter with a predicting scoreboard.
`default_nettype none
class olafft_scoreboard;
  typedef struct {
    logic signed [15:0] sample;
    logic               clipped;
    logic               eos;
  } out_word_t;

  out_word_t        pending_words[$];
  int               errors;
  logic [5:0]       hop_reg;
  logic [15:0]      win_tab[32];
  logic [15:0]      gain_tab[17];
  longint           hist[32];
  longint           acc[64];
  int               since_frame;
  int               produced;
  longint           cos_tab[32] = '{32768, 32139, 30273, 27246, 23170, 18205, 12540, 6393,
    0, -6393, -12540, -18205, -23170, -27246, -30273, -32139,
    -32768, -32139, -30273, -27246, -23170, -18205, -12540, -6393,
    0, 6393, 12540, 18205, 23170, 27246, 30273, 32139};

  function new();
    errors = 0;
    hop_reg = olafft_pkg::HOP_RESET;
    clear_stream();
  endfunction

  function void clear_stream();
    foreach (hist[i]) hist[i] = 0;
    foreach (acc[i]) acc[i] = 0;
    since_frame = 0;
  endfunction

  function longint rnd_shift(longint a, int s);
    return (a + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function int hop_now();
    if (hop_reg < 1) return 1;
    if (hop_reg > 32) return 32;
    return int'(hop_reg);
  endfunction

  function void filter_frame();
    longint v[32];
    longint h[32];
    longint s;
    longint a;
    int b;
    for (int m = 0; m < 32; m++) v[m] = rnd_shift(hist[m] * longint'(win_tab[m]), 15);
    for (int d = 0; d < 32; d++) begin
      s = 0;
      for (int j = 0; j < 32; j++) begin
        b = (j <= 16) ? j : 32 - j;
        s += longint'(gain_tab[b]) * cos_tab[(j * d) % 32];
      end
      h[d] = rnd_shift(s, 20);
    end
    for (int n = 0; n < 32; n++) begin
      s = 0;
      for (int m = 0; m < 32; m++) s += v[m] * h[(n + 32 - m) % 32];
      a = acc[n] + rnd_shift(s, 12);
      if (a > 8388607) a = 8388607;
      if (a < -8388608) a = -8388608;
      acc[n] = a;
    end
  endfunction

  function void emit_words(int cnt, bit last);
    out_word_t w;
    longint val;
    for (int i = 0; i < cnt && produced < 64; i++) begin
      val = acc[i];
      w.clipped = 0;
      if (val > 32767) begin val = 32767; w.clipped = 1; end
      if (val < -32768) begin val = -32768; w.clipped = 1; end
      w.sample = val[15:0];
      w.eos = last && (i + 1 == cnt);
      pending_words.push_back(w);
      produced++;
    end
    for (int i = 0; i < 64; i++) acc[i] = (i + cnt < 64) ? acc[i + cnt] : 0;
  endfunction

  function void shift_hist(int cnt);
    for (int i = 0; i < 32; i++) hist[i] = (i + cnt < 32) ? hist[i + cnt] : 0;
  endfunction

  function void note_input(logic [1:0] op, logic [4:0] idx, logic [15:0] tv,
                           logic signed [15:0] smp, logic last);
    int f;
    int h;
    produced = 0;
    if (op == olafft_pkg::OPC_WIN) begin
      win_tab[idx] = tv;
    end else if (op == olafft_pkg::OPC_GAIN) begin
      if (idx <= 16) gain_tab[idx] = tv;
    end else if (op == olafft_pkg::OPC_SAMPLE) begin
      hist[since_frame] = smp;
      since_frame++;
      if (!last) begin
        if (since_frame >= 32) begin
          h = hop_now();
          filter_frame();
          emit_words(h, 0);
          shift_hist(h);
          since_frame -= h;
        end
      end else begin
        f = since_frame;
        while (f > 0) begin
          h = hop_now();
          filter_frame();
          if (f > h) begin
            emit_words(h, 0);
            shift_hist(h);
            f -= h;
          end else begin
            emit_words(32, 1);
            break;
          end
        end
        clear_stream();
      end
    end
  endfunction

  function void check_result(logic signed [15:0] smp, logic clp, logic eos);
    out_word_t w;
    if (pending_words.size() == 0) begin
      $display("%0t: unexpected word sample=%0d clipped=%0b eos=%0b", $time, smp, clp, eos);
      errors++;
      return;
    end
    w = pending_words.pop_front();
    if (smp !== w.sample) begin
      $display("%0t: sample_out expected %0d actual %0d", $time, w.sample, smp);
      errors++;
    end
    if (clp !== w.clipped) begin
      $display("%0t: clipped expected %0b actual %0b", $time, w.clipped, clp);
      errors++;
    end
    if (eos !== w.eos) begin
      $display("%0t: end_of_signal expected %0b actual %0b", $time, w.eos, eos);
      errors++;
    end
  endfunction
endclass

module tb_overlap_add_fft_filter;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam logic [olafft_pkg::OPC_W-1:0] OPC_NONE = 2'd3;

  logic clk = 0;
  logic rst;
  logic cfg_we;
  logic [olafft_pkg::HOP_W-1:0] cfg_wdata;
  bit calm;
  int quiet_cycles;
  olafft_scoreboard sb;

  olafft_in_if din ();
  olafft_out_if dout ();

  overlap_add_fft_filter u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .din(din.sink), .dout(dout.source)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    dout.ready <= calm || ($urandom_range(0, 99) >= 28);
  end

  always @(posedge clk) begin
    if (!rst && dout.valid && dout.ready) sb.check_result(dout.sample_out, dout.clipped,
                                                          dout.end_of_signal);
    if ((din.valid && din.ready) || (dout.valid && dout.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_word(logic [1:0] op, logic [4:0] idx, logic [15:0] tv,
                           logic signed [15:0] smp, logic last);
    int gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(0, 99) < 28) gap++;
    end
    if (gap > 0) begin
      din.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    din.valid <= 1;
    din.opcode <= op;
    din.table_index <= idx;
    din.table_value <= tv;
    din.sample_in <= smp;
    din.is_last <= last;
    forever begin
      @(posedge clk);
      if (din.ready) break;
    end
    sb.note_input(op, idx, tv, smp, last);
  endtask

  task automatic write_hop(logic [olafft_pkg::HOP_W-1:0] value);
    din.valid <= 0;
    repeat (100) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 0;
    sb.hop_reg = value;
  endtask

  task automatic load_tables(int mode);
    logic [15:0] tv;
    for (int i = 0; i < 32; i++) begin
      case (mode)
        0: tv = 16'd32768;
        1: tv = 16'hFFFF;
        2: tv = (i % 2) ? 16'h0000 : 16'hFFFF;
        default: tv = 16'($urandom);
      endcase
      send_word(olafft_pkg::OPC_WIN, 5'(i), tv, 16'($urandom), 1'($urandom_range(0, 1)));
    end
    for (int i = 0; i < 17; i++) begin
      case (mode)
        0: tv = 16'd4096;
        1: tv = 16'hFFFF;
        2: tv = (i % 2) ? 16'hFFFF : 16'h0000;
        default: tv = 16'($urandom_range(0, 8191));
      endcase
      send_word(olafft_pkg::OPC_GAIN, 5'(i), tv, 16'($urandom), 1'b0);
    end
  endtask

  task automatic wait_drained();
    din.valid <= 0;
    @(posedge clk);
    while (sb.pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic run_signal(int count, int amp, bit pause_mid);
    logic signed [15:0] smp;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 8)
        send_word(($urandom_range(0, 1) != 0) ? OPC_NONE : olafft_pkg::OPC_GAIN,
                  5'($urandom_range(17, 31)), 16'($urandom), 16'($urandom),
                  1'($urandom_range(0, 1)));
      smp = 16'($urandom_range(0, 2 * amp) - amp);
      if ($urandom_range(0, 19) == 0) smp = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
      if (pause_mid && n == count - 1) wait_drained();
      send_word(olafft_pkg::OPC_SAMPLE, 5'($urandom), 16'($urandom), smp, n == count - 1);
    end
    wait_drained();
  endtask

  initial begin
    int hops[8] = '{16, 1, 32, 8, 0, 63, 5, 3};
    int lens[8] = '{33, 34, 6, 10, 4, 3, 10, 4};
    sb = new();
    rst = 1;
    calm = 0;
    cfg_we = 0;
    cfg_wdata = '0;
    quiet_cycles = 0;
    din.valid = 0;
    din.opcode = olafft_pkg::OPC_WIN;
    din.table_index = '0;
    din.table_value = '0;
    din.sample_in = '0;
    din.is_last = 0;
    dout.ready = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    load_tables(0);
    send_word(OPC_NONE, 5'd31, 16'hFFFF, 16'sh7FFF, 1'b1);
    send_word(olafft_pkg::OPC_GAIN, 5'd31, 16'hFFFF, 16'sh8000, 1'b1);
    run_signal(1, 100, 0);
    run_signal(10, 32767, 0);
    for (int p = 0; p < 8; p++) begin
      write_hop(6'(hops[p]));
      calm = (p == 1);
      if (p >= 1 && p <= 3) load_tables(p);
      run_signal(lens[p], (p % 4 == 1) ? 300 : 32767, p == 1);
    end
    calm = 0;
    write_hop(6'd1);
    run_signal(2, 32767, 0);
    write_hop(6'd32);
    run_signal(33, 20000, 0);

    wait_drained();
    repeat (3000) @(posedge clk);
    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: overlap_add_fft_filter.f
+incdir+rtl/core
rtl/core/olafft_pkg.sv
rtl/core/olafft_in_if.sv
rtl/core/olafft_out_if.sv
rtl/core/olafft_ctrl.sv
rtl/core/olafft_dp.sv
rtl/core/overlap_add_fft_filter.sv
sim/tb_overlap_add_fft_filter.sv
